/* rtl/core/jei_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jei_pkg
// Shared types for the Julia escape-time iteration unit.
// ----------------------------------------------------------------------------
package jei_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_MAG,
        ST_SQ,
        ST_CUBE,
        ST_M3,
        ST_DIVR,
        ST_DIVI,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/julia_escape_iteration_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_iteration_unit
// Escape-time iteration of z -> 1/z^3 + c in signed fixed point, using one
// shared 32x32 multiplier with accumulator and one bit-serial divider.
//
// Channel     Dir  Handshake                       Content
// s_axis      in   i_s_axis_tvalid/o_s_axis_tready z_real, z_imag, c_real, c_imag
// m_axis      out  o_m_axis_tvalid/i_m_axis_tready iteration_count; tuser escaped
// cfg         in   i_cfg_wr_en                     max_iterations
//
// Each iteration runs two restoring divisions of 32 + 2*FRACTION_BITS steps
// each; an iteration with a zero divisor skips both divisions.
// Reset is synchronous and active low; the limit resets to 255.
// A new transfer is taken only when idle; a stalled result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module julia_escape_iteration_unit
    import jei_pkg::*;
#(
    parameter int COUNT_BITS    = 12,
    parameter int FRACTION_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [COUNT_BITS-1:0]   i_cfg_wr_data,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // Fields from bit 0: z_real, z_imag, c_real, c_imag (32 bits each).
    input  logic [127:0]            i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // Fields from bit 0: iteration_count, zero fill to whole bytes.
    output logic [((COUNT_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // Fields from bit 0: escaped.
    output logic [0:0]              o_m_axis_tuser
);

    localparam int OUT_W     = ((COUNT_BITS + 7) / 8) * 8;
    localparam int DIV_STEPS = 32 + 2 * FRACTION_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);
    localparam logic signed [65:0] THR    = 66'sd9 <<< (2 * FRACTION_BITS);
    localparam logic signed [65:0] MAX64  = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] MIN64  = -66'sh0_8000_0000_0000_0000;
    localparam logic signed [65:0] MAX32W = 66'sd2147483647;
    localparam logic signed [65:0] MIN32W = -66'sd2147483648;
    localparam logic signed [31:0] MAX32  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32  = 32'sh8000_0000;
    localparam logic [33:0] QCAP  = 34'h2_0000_0000;
    localparam logic [33:0] QPMAX = 34'h0_7FFF_FFFF;
    localparam logic [33:0] QNMAX = 34'h0_8000_0000;

    function automatic logic signed [31:0] fin(input logic signed [65:0] a);
        logic signed [65:0] s;
        logic signed [65:0] sh;
        s = a;
        if (a > MAX64) begin
            s = MAX64;
        end else if (a < MIN64) begin
            s = MIN64;
        end
        sh = s >>> FRACTION_BITS;
        if (sh > MAX32W) begin
            return MAX32;
        end else if (sh < MIN32W) begin
            return MIN32;
        end
        return sh[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647) begin
            return MAX32;
        end else if (s < -33'sd2147483648) begin
            return MIN32;
        end
        return s[31:0];
    endfunction

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_max, r_cnt, r_ocnt;
    logic                  r_esc, r_oesc, r_ovalid, r_fault, r_neg;
    logic [1:0]            r_step;
    logic [DIV_CW-1:0]     r_dcnt;
    logic signed [31:0]    r_zr, r_zi, r_cr, r_ci, r_sr, r_si, r_tr, r_ti, r_vr, r_vi;
    logic signed [65:0]    r_acc;
    logic [63:0]           r_den, r_rem;
    logic [33:0]           r_q;
    logic [31:0]           r_nsh;

    logic signed [31:0] w_opa, w_opb;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_acc;
    logic               w_step_end, w_accept, w_div_last;
    logic [64:0]        w_rem2, w_rem_n;
    logic               w_ge;
    logic [34:0]        w_q2;
    logic [33:0]        w_qn;
    logic signed [31:0] w_dres;
    logic               w_dovf;
    logic [31:0]        w_abs_tr, w_abs_ti;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_div_last = (r_dcnt == DIV_LAST);

    // Shared multiplier operand selection.
    always_comb begin
        w_opa = r_zr;
        w_opb = r_zr;
        unique case (r_state)
            ST_MAG: begin
                w_opa = r_step[0] ? r_zi : r_zr;
                w_opb = r_step[0] ? r_zi : r_zr;
            end
            ST_SQ: begin
                w_opa = r_step[0] ? r_zi : r_zr;
                unique case (r_step)
                    2'd0:    w_opb = r_zr;
                    2'd1:    w_opb = r_zi;
                    2'd2:    w_opb = r_zi;
                    default: w_opb = r_zr;
                endcase
            end
            ST_CUBE: begin
                w_opa = r_step[0] ? r_si : r_sr;
                unique case (r_step)
                    2'd0:    w_opb = r_zr;
                    2'd1:    w_opb = r_zi;
                    2'd2:    w_opb = r_zi;
                    default: w_opb = r_zr;
                endcase
            end
            ST_M3: begin
                w_opa = r_step[0] ? r_ti : r_tr;
                w_opb = r_step[0] ? r_ti : r_tr;
            end
            default: begin
                w_opa = r_zr;
                w_opb = r_zr;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    always_comb begin
        priority if (!r_step[0]) begin
            w_acc = 66'(w_prod);
        end else if ((r_state == ST_SQ || r_state == ST_CUBE) && r_step == 2'd1) begin
            w_acc = r_acc - 66'(w_prod);
        end else begin
            w_acc = r_acc + 66'(w_prod);
        end
    end

    always_comb begin
        unique case (r_state)
            ST_MAG, ST_M3:  w_step_end = (r_step == 2'd1);
            ST_SQ, ST_CUBE: w_step_end = (r_step == 2'd3);
            default:        w_step_end = 1'b0;
        endcase
    end

    // Restoring divider, one quotient bit per cycle.
    assign w_rem2  = {r_rem, r_nsh[31]};
    assign w_ge    = (w_rem2 >= {1'b0, r_den});
    assign w_rem_n = w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
    assign w_q2    = {r_q, w_ge};
    assign w_qn    = (w_q2 > {1'b0, QCAP}) ? QCAP : w_q2[33:0];

    always_comb begin
        w_dovf = 1'b0;
        if (!r_neg) begin
            if (w_qn > QPMAX) begin
                w_dres = MAX32;
                w_dovf = 1'b1;
            end else begin
                w_dres = w_qn[31:0];
            end
        end else begin
            if (w_qn > QNMAX) begin
                w_dres = MIN32;
                w_dovf = 1'b1;
            end else begin
                w_dres = -w_qn[31:0];
            end
        end
    end

    assign w_abs_tr = r_tr[31] ? -r_tr : r_tr;
    assign w_abs_ti = r_ti[31] ? -r_ti : r_ti;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_TEST;
            ST_TEST: n_state = (r_cnt >= r_max) ? ST_DONE : ST_MAG;
            ST_MAG:  if (w_step_end) n_state = (w_acc >= THR) ? ST_DONE : ST_SQ;
            ST_SQ:   if (w_step_end) n_state = ST_CUBE;
            ST_CUBE: if (w_step_end) n_state = ST_M3;
            ST_M3:   if (w_step_end) n_state = (w_acc == '0) ? ST_UPD : ST_DIVR;
            ST_DIVR: if (w_div_last) n_state = ST_DIVI;
            ST_DIVI: if (w_div_last) n_state = ST_UPD;
            ST_UPD:  n_state = r_fault ? ST_DONE : ST_TEST;
            ST_DONE: if (!r_ovalid || i_m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        o_m_axis_tvalid = r_ovalid;
        o_m_axis_tdata  = OUT_W'(r_ocnt);
        o_m_axis_tuser  = r_oesc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_max    <= COUNT_BITS'(255);
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_dcnt   <= '0;
            r_cnt    <= '0;
            r_esc    <= 1'b0;
            r_fault  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            priority if (r_state == ST_DONE && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_MAG || r_state == ST_SQ || r_state == ST_CUBE ||
                r_state == ST_M3) begin
                r_step <= w_step_end ? 2'd0 : r_step + 2'd1;
            end
            if (r_state == ST_DIVR || r_state == ST_DIVI) begin
                r_dcnt <= w_div_last ? '0 : r_dcnt + 1'b1;
            end
            if (w_accept) begin
                r_cnt <= '0;
                r_esc <= 1'b0;
            end
            if (r_state == ST_MAG && w_step_end && w_acc >= THR) begin
                r_esc <= 1'b1;
            end
            if (r_state == ST_M3 && w_step_end) begin
                r_fault <= (w_acc == '0);
            end
            if ((r_state == ST_DIVR || r_state == ST_DIVI) && w_div_last && w_dovf) begin
                r_fault <= 1'b1;
            end
            if (r_state == ST_UPD) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_fault) begin
                    r_esc <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zr <= i_s_axis_tdata[31:0];
            r_zi <= i_s_axis_tdata[63:32];
            r_cr <= i_s_axis_tdata[95:64];
            r_ci <= i_s_axis_tdata[127:96];
        end
        if (r_state == ST_MAG || r_state == ST_SQ || r_state == ST_CUBE ||
            r_state == ST_M3) begin
            r_acc <= w_acc;
        end
        if (r_state == ST_SQ && r_step == 2'd1) r_sr <= fin(w_acc);
        if (r_state == ST_SQ && r_step == 2'd3) r_si <= fin(w_acc);
        if (r_state == ST_CUBE && r_step == 2'd1) r_tr <= fin(w_acc);
        if (r_state == ST_CUBE && r_step == 2'd3) r_ti <= fin(w_acc);
        if (r_state == ST_M3 && w_step_end) begin
            r_den <= w_acc[63:0];
            r_vr  <= MAX32;
            r_vi  <= MAX32;
            r_nsh <= w_abs_tr;
            r_neg <= r_tr[31];
            r_rem <= '0;
            r_q   <= '0;
        end
        if (r_state == ST_DIVR || r_state == ST_DIVI) begin
            if (w_div_last) begin
                r_rem <= '0;
                r_q   <= '0;
                if (r_state == ST_DIVR) begin
                    r_vr  <= w_dres;
                    r_nsh <= w_abs_ti;
                    r_neg <= !r_ti[31] && (r_ti != '0);
                end else begin
                    r_vi <= w_dres;
                end
            end else begin
                r_rem <= w_rem_n[63:0];
                r_q   <= w_qn;
                r_nsh <= {r_nsh[30:0], 1'b0};
            end
        end
        if (r_state == ST_UPD) begin
            r_zr <= add_sat(r_vr, r_cr);
            r_zi <= add_sat(r_vi, r_ci);
        end
        if (r_state == ST_DONE && (!r_ovalid || i_m_axis_tready)) begin
            r_ocnt <= r_cnt;
            r_oesc <= r_esc;
        end
    end

    a_cnt_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt <= r_max))
        else $error("iteration count passed the limit");

    a_not_escaped_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_esc) |-> (r_cnt == r_max))
        else $error("non-escaped result before reaching the limit");

    a_quotient_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVR || r_state == ST_DIVI) |-> (r_q <= QCAP))
        else $error("quotient above its cap");

    a_div_enters_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVR && $past(r_state) == ST_M3) |-> (r_dcnt == '0 && r_q == '0))
        else $error("divider started with stale state");

endmodule
